// ===== design/bdl_pkg.sv =====
package bdl_pkg;

  localparam int SECTOR_WORDS = 128;
  localparam int WORD_AW      = $clog2(SECTOR_WORDS);
  localparam int MAP_PAIRS    = 8;
  localparam int PAIR_W       = 3;
  localparam int CNT_W        = 4;
  localparam int TDATA_W      = 72;
  localparam int TUSER_W      = 3;

  localparam logic [31:0]        LABEL_MAGIC    = 32'h8256_4557;
  localparam logic [WORD_AW-1:0] MAP_OFFSET     = WORD_AW'(80);
  localparam logic [WORD_AW-1:0] TRAIL_OFFSET   = WORD_AW'(96);
  localparam logic [WORD_AW-1:0] LAST_LABEL_POS = WORD_AW'(31);

  // label status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;

  typedef struct packed {
    logic       load;        // take sector words
    logic       rd_trail;    // read trailing magic
    logic       rd_s;        // read start word of the current pair
    logic       rd_z;        // read size word of the current pair
    logic       latch_s;     // capture start word from the store
    logic       set_status;
    logic [1:0] status;
    logic       take_pair;   // evaluate current pair and advance
    logic       emit_final;  // push the closing result
  } bdl_cmd_t;

  typedef struct packed {
    logic last_word;
    logic label_seen;
    logic trail_ok;
    logic limit_zero;
    logic pair_nonzero;
    logic pend_valid;
    logic loop_done;
    logic out_free;
  } bdl_stat_t;

endpackage

// ===== design/bdl_ram.sv =====
module bdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bdl_ctrl.sv =====
module bdl_ctrl
  import bdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bdl_stat_t stat,
  output bdl_cmd_t  cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_TRAIL = 3'd1;
  localparam logic [2:0] S_TCHK  = 3'd2;
  localparam logic [2:0] S_RDS   = 3'd3;
  localparam logic [2:0] S_RDZ   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        cmd.load = 1'b1;
        if (stat.last_word) begin
          state_next = S_TRAIL;
        end
      end
      S_TRAIL: begin
        if (!stat.label_seen) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NONE;
          state_next     = S_FINAL;
        end else begin
          cmd.rd_trail = 1'b1;
          state_next   = S_TCHK;
        end
      end
      S_TCHK: begin
        cmd.set_status = 1'b1;
        if (!stat.trail_ok) begin
          cmd.status = ST_BAD;
          state_next = S_FINAL;
        end else begin
          cmd.status = ST_OK;
          state_next = stat.limit_zero ? S_FINAL : S_RDS;
        end
      end
      S_RDS: begin
        cmd.rd_s   = 1'b1;
        state_next = S_RDZ;
      end
      S_RDZ: begin
        cmd.rd_z    = 1'b1;
        cmd.latch_s = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        // hold while an earlier entry must leave but the output slot is full
        if (!(stat.pair_nonzero && stat.pend_valid && !stat.out_free)) begin
          cmd.take_pair = 1'b1;
          state_next    = stat.loop_done ? S_FINAL : S_RDS;
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// ===== design/bdl_datapath.sv =====
module bdl_datapath
  import bdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  input  logic               s_axis_tvalid,
  input  logic [31:0]        s_axis_tdata,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [TUSER_W-1:0] m_axis_tuser,
  output logic               m_axis_tlast,
  input  bdl_cmd_t           cmd,
  output bdl_stat_t          stat
);

  logic [CNT_W-1:0]   max_entries;
  logic [WORD_AW-1:0] word_count;
  logic [4:0]         label_pos;
  logic               label_seen;
  logic [1:0]         label_status;
  logic [PAIR_W-1:0]  pair_idx;
  logic [CNT_W-1:0]   found_cnt;
  logic [31:0]        s_word;

  logic               pend_valid;
  logic [31:0]        pend_start;
  logic [31:0]        pend_len;
  logic [PAIR_W-1:0]  pend_num;

  logic               out_valid;
  logic [31:0]        out_start;
  logic [31:0]        out_len;
  logic [PAIR_W-1:0]  out_num;
  logic               out_ev;
  logic [1:0]         out_st;
  logic               out_last;

  logic               in_acc;
  logic               seen_cur;
  logic               re;
  logic [WORD_AW-1:0] raddr;
  logic [WORD_AW-1:0] pair_addr;
  logic [31:0]        rdata;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   found_inc;
  logic               out_free;
  logic               push_pend;

  assign s_axis_tready = cmd.load;
  assign in_acc        = s_axis_tvalid && cmd.load;

  // a new sector restarts the search
  assign seen_cur = (word_count == '0) ? 1'b0 : label_seen;

  assign pair_addr = {2'b00, label_pos} + MAP_OFFSET
                   + {{(WORD_AW-PAIR_W-1){1'b0}}, pair_idx, 1'b0};
  assign re = cmd.rd_trail || cmd.rd_s || cmd.rd_z;

  always_comb begin
    raddr = pair_addr;
    if (cmd.rd_trail) begin
      raddr = {2'b00, label_pos} + TRAIL_OFFSET;
    end else if (cmd.rd_z) begin
      raddr = pair_addr + WORD_AW'(1);
    end
  end

  bdl_ram #(
    .WIDTH(32),
    .DEPTH(SECTOR_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (in_acc),
    .waddr(word_count),
    .wdata(s_axis_tdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign limit = (max_entries > CNT_W'(MAP_PAIRS)) ? CNT_W'(MAP_PAIRS) : max_entries;
  assign found_inc = found_cnt + CNT_W'(1);
  assign out_free  = !out_valid || m_axis_tready;
  assign push_pend = cmd.take_pair && stat.pair_nonzero && pend_valid;

  always_comb begin
    stat.last_word    = in_acc && (word_count == WORD_AW'(SECTOR_WORDS - 1));
    stat.label_seen   = label_seen;
    stat.trail_ok     = (rdata == LABEL_MAGIC) || (rdata == '0);
    stat.limit_zero   = (limit == '0);
    stat.pair_nonzero = (s_word != '0) || (rdata != '0);
    stat.pend_valid   = pend_valid;
    stat.loop_done    = (pair_idx == PAIR_W'(MAP_PAIRS - 1))
                     || (stat.pair_nonzero && (found_inc == limit));
    stat.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= CNT_W'(MAP_PAIRS);
    end else if (cfg_wr_en) begin
      max_entries <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
      label_seen <= 1'b0;
      label_pos  <= '0;
    end else if (in_acc) begin
      word_count <= word_count + WORD_AW'(1);
      if (!seen_cur && (word_count <= LAST_LABEL_POS) && (s_axis_tdata == LABEL_MAGIC)) begin
        label_seen <= 1'b1;
        label_pos  <= word_count[4:0];
      end else if (word_count == '0) begin
        label_seen <= 1'b0;
        label_pos  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      label_status <= cmd.status;
    end
    if (cmd.latch_s) begin
      s_word <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pair_idx   <= '0;
      found_cnt  <= '0;
    end else if (cmd.emit_final) begin
      pend_valid <= 1'b0;
      pair_idx   <= '0;
      found_cnt  <= '0;
    end else if (cmd.take_pair) begin
      pair_idx <= pair_idx + PAIR_W'(1);
      if (stat.pair_nonzero) begin
        pend_valid <= 1'b1;
        found_cnt  <= found_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pair && stat.pair_nonzero) begin
      pend_start <= s_word;
      pend_len   <= rdata;
      pend_num   <= found_cnt[PAIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_final || push_pend) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend || (cmd.emit_final && pend_valid)) begin
      out_start <= pend_start;
      out_len   <= pend_len;
      out_num   <= pend_num;
      out_ev    <= 1'b1;
      out_st    <= ST_OK;
      out_last  <= cmd.emit_final;
    end else if (cmd.emit_final) begin
      out_start <= '0;
      out_len   <= '0;
      out_num   <= '0;
      out_ev    <= 1'b0;
      out_st    <= label_status;
      out_last  <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TDATA_W-64-PAIR_W){1'b0}}, out_num, out_len, out_start};
  assign m_axis_tuser  = {out_st, out_ev};
  assign m_axis_tlast  = out_last;

  a_final_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_final |-> out_free)
    else $error("final result pushed into a full output slot");

  a_entry_slot: assert property (@(posedge clk) disable iff (rst)
    push_pend |-> out_free)
    else $error("entry pushed into a full output slot");

  a_found_limit: assert property (@(posedge clk) disable iff (rst)
    found_cnt <= limit)
    else $error("more entries found than the limit allows");

  a_pend_ok: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (label_status == ST_OK))
    else $error("pending entry without a valid label");

  a_stop_load: assert property (@(posedge clk) disable iff (rst)
    stat.last_word |=> !s_axis_tready)
    else $error("input still open after the last word of a sector");

endmodule

// ===== design/bsd_disklabel_sector_parser.sv =====
// Disk label parser for one 512-byte sector.
//
// s_axis carries the sector as 128 little-endian 32-bit words, one item per
// word, in order; one word is taken per cycle while tready is high. The words
// are kept in a 128-entry store. After the last word, tready drops and the
// block parses: it looks up the label and, if found, checks the trailing
// magic; if it is good and max_entries is nonzero, it evaluates map pairs,
// each after two reads through the single read port of the store. Then the
// closing result goes out and loading resumes. m_axis carries partition
// entries and status results; tlast marks the final result of a sector. The
// output is a register: a result stays until taken, and a stalled receiver
// holds the parser on the next result, while the waiting one stays valid.
// cfg_wr_en/cfg_wr_data set max_entries; the user must write it only when
// idle; the block does not enforce this. Reset (rst, synchronous) returns
// the block to word 0 of a new sector with max_entries at 8 and no result
// pending; the store is not cleared.
module bsd_disklabel_sector_parser
  import bdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,    // max_entries
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // sector_word
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // part_start, part_length, entry_number
  output logic [TUSER_W-1:0] m_axis_tuser,   // entry_valid, label_status
  output logic               m_axis_tlast    // last_of_run
);

  bdl_cmd_t  cmd;
  bdl_stat_t stat;

  bdl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .cmd (cmd)
  );

  bdl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// ===== test/bsd_disklabel_sector_parser_test.sv =====
`timescale 1ns / 1ps

module bsd_disklabel_sector_parser_test;
  import bdl_pkg::*;

  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_SECTORS = 40;
  localparam int DIR_ROWS       = 18;

  typedef enum logic [2:0] {
    SEC_RANDOM, SEC_ZEROS, SEC_ONES, SEC_LABEL, SEC_FAR, SEC_TWICE
  } sector_kind_e;

  typedef enum logic [1:0] {TR_MAGIC, TR_ZERO, TR_BAD} trail_e;

  typedef enum logic [2:0] {
    PR_RANDOM, PR_FULL, PR_EMPTY, PR_SPARSE, PR_EXTREME
  } pair_fill_e;

  typedef struct packed {
    logic         set_cfg;
    logic [3:0]   cfg;
    sector_kind_e kind;
    logic [6:0]   pos;
    trail_e       trail;
    pair_fill_e   pairs;
    logic         fixed;
    logic [1:0]   fixed_status;
  } sector_row_t;

  typedef struct packed {
    logic [31:0] pstart;
    logic [31:0] plength;
    logic [2:0]  entry_num;
    logic        entry_ok;
    logic [1:0]  status;
    logic        last_flag;
  } part_result_t;

  // rows marked fixed carry their expected status; the rest go through the predictor
  localparam sector_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, 4'd0,  SEC_RANDOM, 7'd0,   TR_MAGIC, PR_RANDOM,  1'b1, ST_NONE},
    '{1'b0, 4'd0,  SEC_ZEROS,  7'd0,   TR_MAGIC, PR_RANDOM,  1'b1, ST_NONE},
    '{1'b0, 4'd0,  SEC_ONES,   7'd0,   TR_MAGIC, PR_RANDOM,  1'b1, ST_NONE},
    '{1'b0, 4'd0,  SEC_LABEL,  7'd0,   TR_MAGIC, PR_FULL,    1'b0, ST_OK},
    '{1'b0, 4'd0,  SEC_LABEL,  7'd31,  TR_ZERO,  PR_EXTREME, 1'b0, ST_OK},
    '{1'b0, 4'd0,  SEC_FAR,    7'd32,  TR_MAGIC, PR_FULL,    1'b1, ST_NONE},
    '{1'b0, 4'd0,  SEC_FAR,    7'd127, TR_MAGIC, PR_FULL,    1'b1, ST_NONE},
    '{1'b0, 4'd0,  SEC_LABEL,  7'd7,   TR_BAD,   PR_FULL,    1'b1, ST_BAD},
    '{1'b0, 4'd0,  SEC_LABEL,  7'd0,   TR_MAGIC, PR_EMPTY,   1'b1, ST_OK},
    '{1'b1, 4'd0,  SEC_LABEL,  7'd3,   TR_MAGIC, PR_FULL,    1'b1, ST_OK},
    '{1'b1, 4'd1,  SEC_LABEL,  7'd12,  TR_ZERO,  PR_FULL,    1'b0, ST_OK},
    '{1'b1, 4'd15, SEC_LABEL,  7'd20,  TR_MAGIC, PR_FULL,    1'b0, ST_OK},
    '{1'b1, 4'd8,  SEC_LABEL,  7'd5,   TR_MAGIC, PR_SPARSE,  1'b0, ST_OK},
    '{1'b0, 4'd0,  SEC_TWICE,  7'd2,   TR_MAGIC, PR_RANDOM,  1'b0, ST_OK},
    '{1'b0, 4'd0,  SEC_TWICE,  7'd4,   TR_BAD,   PR_FULL,    1'b1, ST_BAD},
    '{1'b1, 4'd3,  SEC_LABEL,  7'd31,  TR_BAD,   PR_FULL,    1'b1, ST_BAD},
    '{1'b0, 4'd0,  SEC_LABEL,  7'd16,  TR_ZERO,  PR_RANDOM,  1'b0, ST_OK},
    '{1'b1, 4'd9,  SEC_LABEL,  7'd1,   TR_MAGIC, PR_EXTREME, 1'b0, ST_OK}
  };

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [CNT_W-1:0]   cfg_wr_data;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0] m_axis_tuser;
  logic               m_axis_tlast;

  // predictor copy of the block
  logic [31:0]  sector_mem [SECTOR_WORDS];
  logic [6:0]   word_idx   = '0;
  logic [4:0]   label_pos  = '0;
  logic         seen_label = 1'b0;
  logic [3:0]   max_ent    = 4'd8;

  part_result_t expected_parts [$];
  sector_row_t  sector_tags [$];
  logic [31:0]  sector_buf [SECTOR_WORDS];

  int mismatches = 0;
  int sectors_sent = 0;
  int n_entries = 0;
  int n_none = 0;
  int n_bad = 0;
  int n_empty = 0;
  int burst_left = 0;
  int idle_count = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  bsd_disklabel_sector_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic part_result_t status_only(input logic [1:0] st);
    return '{32'd0, 32'd0, 3'd0, 1'b0, st, 1'b1};
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // advance the predictor by one sector word
  task automatic take_word(input logic [31:0] w);
    logic [6:0]   idx;
    logic [31:0]  trail_word;
    logic [31:0]  ps;
    logic [31:0]  pl;
    part_result_t held;
    sector_row_t  tag;
    int           lim;
    int           n;
    int           base;
    idx = word_idx;
    if (idx == 7'd0) begin
      seen_label = 1'b0;
      label_pos = '0;
    end
    sector_mem[idx] = w;
    if (!seen_label && idx <= LAST_LABEL_POS && w == LABEL_MAGIC) begin
      seen_label = 1'b1;
      label_pos = idx[4:0];
    end
    word_idx = idx + 7'd1;
    if (idx != 7'(SECTOR_WORDS - 1)) return;

    tag = sector_tags.pop_front();
    if (tag.fixed) begin
      expected_parts.push_back(status_only(tag.fixed_status));
      return;
    end
    if (!seen_label) begin
      expected_parts.push_back(status_only(ST_NONE));
      return;
    end
    base = int'(label_pos);
    trail_word = sector_mem[base + int'(TRAIL_OFFSET)];
    if (trail_word != LABEL_MAGIC && trail_word != 32'd0) begin
      expected_parts.push_back(status_only(ST_BAD));
      return;
    end
    lim = (max_ent > MAP_PAIRS) ? MAP_PAIRS : int'(max_ent);
    n = 0;
    held = '0;
    for (int i = 0; i < MAP_PAIRS; i++) begin
      if (n < lim) begin
        ps = sector_mem[base + int'(MAP_OFFSET) + 2 * i];
        pl = sector_mem[base + int'(MAP_OFFSET) + 2 * i + 1];
        if (ps != 32'd0 || pl != 32'd0) begin
          // hold each entry back one step so the final one can be marked
          if (n > 0) expected_parts.push_back(held);
          held = '{ps, pl, 3'(n), 1'b1, ST_OK, 1'b0};
          n++;
        end
      end
    end
    if (n == 0) begin
      expected_parts.push_back(status_only(ST_OK));
    end else begin
      held.last_flag = 1'b1;
      expected_parts.push_back(held);
    end
  endtask

  task automatic check_part;
    part_result_t got;
    part_result_t want;
    got.pstart    = m_axis_tdata[31:0];
    got.plength   = m_axis_tdata[63:32];
    got.entry_num = m_axis_tdata[66:64];
    got.entry_ok  = m_axis_tuser[0];
    got.status    = m_axis_tuser[2:1];
    got.last_flag = m_axis_tlast;
    if (got.entry_ok) n_entries++;
    else if (got.status == ST_NONE) n_none++;
    else if (got.status == ST_BAD) n_bad++;
    else n_empty++;
    if (expected_parts.size() == 0) begin
      report_mismatch($sformatf("unexpected result start %h len %h status %0d",
                                got.pstart, got.plength, got.status));
      return;
    end
    want = expected_parts.pop_front();
    if (got !== want || m_axis_tdata[TDATA_W-1:67] !== '0) begin
      report_mismatch($sformatf(
        "got %h/%h #%0d v%b st%0d l%b pad %h, want %h/%h #%0d v%b st%0d l%b",
        got.pstart, got.plength, got.entry_num, got.entry_ok, got.status,
        got.last_flag, m_axis_tdata[TDATA_W-1:67], want.pstart, want.plength,
        want.entry_num, want.entry_ok, want.status, want.last_flag));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) take_word(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_part();
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_max_entries(input logic [3:0] v);
    // wait until the block has drained and settled
    while (expected_parts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_ent = v;
  endtask

  task automatic build_sector(input sector_row_t row);
    logic [31:0] s;
    logic [31:0] z;
    int          p2;
    int          pick;
    for (int i = 0; i < SECTOR_WORDS; i++) begin
      case (row.kind)
        SEC_ZEROS: sector_buf[i] = 32'd0;
        SEC_ONES:  sector_buf[i] = 32'hFFFF_FFFF;
        default:   sector_buf[i] = $urandom;
      endcase
    end
    // keep stray magic out of the label window
    for (int i = 0; i <= int'(LAST_LABEL_POS); i++) begin
      if (sector_buf[i] == LABEL_MAGIC) sector_buf[i] = sector_buf[i] ^ 32'd1;
    end
    if (row.kind == SEC_FAR) sector_buf[row.pos] = LABEL_MAGIC;
    if (row.kind == SEC_LABEL || row.kind == SEC_TWICE) begin
      sector_buf[row.pos] = LABEL_MAGIC;
      case (row.trail)
        TR_MAGIC: s = LABEL_MAGIC;
        TR_ZERO:  s = 32'd0;
        default: begin
          s = $urandom;
          if (s == 32'd0 || s == LABEL_MAGIC) s = 32'd1;
        end
      endcase
      sector_buf[int'(row.pos) + int'(TRAIL_OFFSET)] = s;
      for (int i = 0; i < MAP_PAIRS; i++) begin
        case (row.pairs)
          PR_FULL: begin
            s = $urandom | 32'd1;
            z = $urandom;
          end
          PR_EMPTY: begin
            s = 32'd0;
            z = 32'd0;
          end
          PR_SPARSE: begin
            s = (i % 2 == 1) ? $urandom : 32'd0;
            z = (i % 2 == 1) ? ($urandom | 32'd1) : 32'd0;
          end
          PR_EXTREME: begin
            s = (i % 2 == 1 && i != 7) ? 32'd0 : 32'hFFFF_FFFF;
            z = (i % 2 == 1 || i == 6) ? 32'hFFFF_FFFF : 32'd0;
          end
          default: begin
            pick = $urandom_range(0, 3);
            s = (pick == 0 || pick == 1) ? 32'd0 : $urandom | 32'd1;
            z = (pick == 0 || pick == 2) ? 32'd0 : $urandom | 32'd1;
            if (pick == 3) s = $urandom;
          end
        endcase
        sector_buf[int'(row.pos) + int'(MAP_OFFSET) + 2 * i]     = s;
        sector_buf[int'(row.pos) + int'(MAP_OFFSET) + 2 * i + 1] = z;
      end
      if (row.kind == SEC_TWICE) begin
        // a later copy with a clean trailer must not win over the first
        p2 = int'(row.pos) + 1 + $urandom_range(0, 30 - int'(row.pos));
        sector_buf[p2] = LABEL_MAGIC;
        sector_buf[p2 + int'(TRAIL_OFFSET)] = LABEL_MAGIC;
      end
    end
  endtask

  task automatic send_sector(input sector_row_t row);
    if (row.set_cfg) write_max_entries(row.cfg);
    build_sector(row);
    sector_tags.push_back(row);
    for (int i = 0; i < SECTOR_WORDS; i++) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= sector_buf[i];
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      if (i == SECTOR_WORDS - 1) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end else if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    sectors_sent++;
  endtask

  // receiver: spans of differing readiness, plus one long hold-off
  initial begin
    int mode;
    int span;
    int tick;
    tick = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (tick % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
        tick++;
      end
    end
  end

  initial begin
    sector_row_t row;
    int          r;
    int          c;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++) send_sector(DIRECTED[k]);

    hold_request = 1'b1;
    for (int k = 0; k < RANDOM_SECTORS; k++) begin
      r = $urandom_range(0, 99);
      row = '0;
      row.kind = (r < 60) ? SEC_LABEL : (r < 72) ? SEC_TWICE : (r < 84) ? SEC_RANDOM :
                 (r < 93) ? SEC_FAR : (r % 2 == 1) ? SEC_ONES : SEC_ZEROS;
      if (row.kind == SEC_FAR) row.pos = 7'($urandom_range(32, 127));
      else if (row.kind == SEC_TWICE) row.pos = 7'($urandom_range(0, 30));
      else row.pos = 7'($urandom_range(0, 31));
      r = $urandom_range(0, 99);
      row.trail = (r < 45) ? TR_MAGIC : (r < 85) ? TR_ZERO : TR_BAD;
      r = $urandom_range(0, 9);
      row.pairs = (r < 5) ? PR_RANDOM : (r < 7) ? PR_FULL : (r == 7) ? PR_SPARSE :
                  (r == 8) ? PR_EMPTY : PR_EXTREME;
      // first random sector leaves the setting alone so the hold-off meets live traffic
      row.set_cfg = (k % 6 == 5);
      c = $urandom_range(0, 5);
      row.cfg = (c == 0) ? 4'd0 : (c == 1) ? 4'd1 : (c == 2) ? 4'd8 : (c == 3) ? 4'd15 :
                4'($urandom_range(0, 15));
      send_sector(row);
    end

    while (expected_parts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("summary: %0d sectors, %0d partition entries, %0d empty labels",
             sectors_sent, n_entries, n_empty);
    $display("summary: %0d without label, %0d bad trailer, %0d mismatches",
             n_none, n_bad, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
